// ===== sv/dtd_pkg.sv =====
// shared types, constants and calendar tables of the datetime difference block
`timescale 1ns / 1ps

package dtd_pkg;

  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned DAYNUM_W   = 23;
  localparam int unsigned DOY_W      = 9;
  localparam int unsigned QUOT_W     = 8;
  localparam int unsigned NUM_STAGES = 4;

  localparam logic [YEAR_W-1:0] YEAR_LIMIT = 14'd9999;

  // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SH for every 14-bit y
  localparam int unsigned DIV100_MUL = 5243;
  localparam int unsigned DIV100_SH  = 19;
  localparam int unsigned DIV100_PW  = YEAR_W + 13;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_MAR = 4'd3;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [5:0] MINS_PER_HOUR = 6'd60;
  localparam logic [5:0] SECS_PER_MIN  = 6'd60;

  typedef struct packed {
    logic [4:0]  first_day;
    logic [3:0]  first_month;
    logic [13:0] first_year;
    logic [4:0]  first_hours;
    logic [5:0]  first_minutes;
    logic [5:0]  first_seconds;
    logic [4:0]  second_day;
    logic [3:0]  second_month;
    logic [13:0] second_year;
    logic [4:0]  second_hours;
    logic [5:0]  second_minutes;
    logic [5:0]  second_seconds;
  } in_t;

  typedef struct packed {
    logic        valid_res;
    logic [21:0] diff_days;
    logic [4:0]  diff_hours;
    logic [5:0]  diff_minutes;
    logic [5:0]  diff_seconds;
  } out_t;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic [4:0]        hours;
    logic [5:0]        minutes;
    logic [5:0]        seconds;
  } stamp_t;

  // one timestamp as day number plus time of day
  typedef struct packed {
    logic                ok;
    logic [DAYNUM_W-1:0] day_num;
    logic [4:0]          hours;
    logic [5:0]          minutes;
    logic [5:0]          seconds;
  } norm_t;

  // load enables of the two register stages inside one module
  typedef struct packed {
    logic en_a;
    logic en_b;
  } stage_en_t;

  function automatic logic [DOY_W-1:0] days_before_month(input logic [3:0] m);
    logic [DOY_W-1:0] r;
    unique case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] m);
    logic [4:0] r;
    unique case (m) inside
      4'd2:                                      r = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/dtd_conv.sv =====
// two-stage conversion of one timestamp into day number and time of day
`timescale 1ns / 1ps

module dtd_conv (
  input  logic                clk_i,
  input  dtd_pkg::stage_en_t  en_i,
  input  dtd_pkg::stamp_t     stamp_i,
  output dtd_pkg::norm_t      norm_o
);

  // stage a: quotients, year times 365, day within common year
  logic [dtd_pkg::YEAR_W-1:0]    year_q;
  logic [dtd_pkg::QUOT_W-1:0]    qy_q, qp_q;
  logic [dtd_pkg::DAYNUM_W-1:0]  y365_q;
  logic [dtd_pkg::DOY_W-1:0]     doy_q;
  logic [3:0]                    month_q;
  logic [4:0]                    day_q;
  logic [4:0]                    hours_q;
  logic [5:0]                    minutes_q, seconds_q;
  logic                          pre_ok_q;

  logic [dtd_pkg::YEAR_W-1:0]    year_m1;
  logic [dtd_pkg::DIV100_PW-1:0] prod_y, prod_p;
  logic                          pre_ok_d;

  always_comb begin
    year_m1 = stamp_i.year - dtd_pkg::YEAR_W'(1);
    prod_y  = dtd_pkg::DIV100_PW'(stamp_i.year) * dtd_pkg::DIV100_PW'(dtd_pkg::DIV100_MUL);
    prod_p  = dtd_pkg::DIV100_PW'(year_m1) * dtd_pkg::DIV100_PW'(dtd_pkg::DIV100_MUL);
    pre_ok_d = (stamp_i.year < dtd_pkg::YEAR_LIMIT)
            && (stamp_i.month >= dtd_pkg::MONTH_JAN) && (stamp_i.month <= dtd_pkg::MONTH_DEC)
            && (stamp_i.day != 5'd0)
            && (stamp_i.hours < dtd_pkg::HOURS_PER_DAY)
            && (stamp_i.minutes < dtd_pkg::MINS_PER_HOUR)
            && (stamp_i.seconds < dtd_pkg::SECS_PER_MIN);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      year_q    <= stamp_i.year;
      qy_q      <= prod_y[dtd_pkg::DIV100_SH +: dtd_pkg::QUOT_W];
      qp_q      <= prod_p[dtd_pkg::DIV100_SH +: dtd_pkg::QUOT_W];
      y365_q    <= dtd_pkg::DAYNUM_W'(stamp_i.year) * dtd_pkg::DAYNUM_W'(365);
      doy_q     <= dtd_pkg::days_before_month(stamp_i.month) + dtd_pkg::DOY_W'(stamp_i.day);
      month_q   <= stamp_i.month;
      day_q     <= stamp_i.day;
      hours_q   <= stamp_i.hours;
      minutes_q <= stamp_i.minutes;
      seconds_q <= stamp_i.seconds;
      pre_ok_q  <= pre_ok_d;
    end
  end

  // stage b: leap year, leap days before the year, day number
  logic                         leap;
  logic [4:0]                   max_day;
  logic [dtd_pkg::YEAR_W-1:0]   p_year;
  logic [12:0]                  leaps_before;
  dtd_pkg::norm_t               norm_d, norm_q;

  always_comb begin
    leap = (year_q[1:0] == 2'd0)
        && (((dtd_pkg::YEAR_W'(qy_q) * dtd_pkg::YEAR_W'(100)) != year_q) || (qy_q[1:0] == 2'd0));
    max_day = dtd_pkg::month_length(month_q)
            + 5'((month_q == dtd_pkg::MONTH_FEB) && leap);
    p_year = year_q - dtd_pkg::YEAR_W'(1);
    // year 0 counts as leap, hence the extra one
    if (year_q == '0) begin
      leaps_before = '0;
    end else begin
      leaps_before = 13'(p_year[dtd_pkg::YEAR_W-1:2]) - 13'(qp_q)
                   + 13'(qp_q[dtd_pkg::QUOT_W-1:2]) + 13'd1;
    end
    norm_d.ok      = pre_ok_q && (day_q <= max_day);
    norm_d.day_num = y365_q + dtd_pkg::DAYNUM_W'(leaps_before) + dtd_pkg::DAYNUM_W'(doy_q)
                   + dtd_pkg::DAYNUM_W'(leap && (month_q >= dtd_pkg::MONTH_MAR));
    norm_d.hours   = hours_q;
    norm_d.minutes = minutes_q;
    norm_d.seconds = seconds_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      norm_q <= norm_d;
    end
  end

  assign norm_o = norm_q;

endmodule

// ===== sv/dtd_diff.sv =====
// ordering of the two timestamps and mixed-radix subtraction
`timescale 1ns / 1ps

module dtd_diff (
  input  logic                clk_i,
  input  dtd_pkg::stage_en_t  en_i,
  input  dtd_pkg::norm_t      first_i,
  input  dtd_pkg::norm_t      second_i,
  output dtd_pkg::out_t       res_o
);

  // stage a: put the later timestamp on top
  dtd_pkg::norm_t big_q, small_q;
  logic           ok_q;
  logic           second_later;

  always_comb begin
    second_later = {second_i.day_num, second_i.hours, second_i.minutes, second_i.seconds}
                 > {first_i.day_num, first_i.hours, first_i.minutes, first_i.seconds};
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_a) begin
      big_q   <= second_later ? second_i : first_i;
      small_q <= second_later ? first_i : second_i;
      ok_q    <= first_i.ok && second_i.ok;
    end
  end

  // stage b: subtract with borrows through seconds, minutes, hours, days
  logic                          bor_s, bor_m, bor_h;
  logic [5:0]                    sec, mins;
  logic [4:0]                    hrs;
  logic [dtd_pkg::DAYNUM_W-1:0]  days;
  dtd_pkg::out_t                 res_d, res_q;

  always_comb begin
    bor_s = big_q.seconds < small_q.seconds;
    sec   = big_q.seconds - small_q.seconds + (bor_s ? dtd_pkg::SECS_PER_MIN : 6'd0);
    bor_m = {1'b0, big_q.minutes} < ({1'b0, small_q.minutes} + 7'(bor_s));
    mins  = big_q.minutes - small_q.minutes - 6'(bor_s)
          + (bor_m ? dtd_pkg::MINS_PER_HOUR : 6'd0);
    bor_h = {1'b0, big_q.hours} < ({1'b0, small_q.hours} + 6'(bor_m));
    hrs   = big_q.hours - small_q.hours - 5'(bor_m)
          + (bor_h ? dtd_pkg::HOURS_PER_DAY : 5'd0);
    days  = big_q.day_num - small_q.day_num - dtd_pkg::DAYNUM_W'(bor_h);
    res_d = '0;
    if (ok_q) begin
      res_d.valid_res    = 1'b1;
      res_d.diff_days    = days[21:0];
      res_d.diff_hours   = hrs;
      res_d.diff_minutes = mins;
      res_d.diff_seconds = sec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.en_b) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

// ===== sv/datetime_difference_top.sv =====
// top level of the datetime difference block: pipeline control and wiring
`timescale 1ns / 1ps

// Usage
// Input channel: in_valid_i / in_stall_o / in_data_i carries a word of two
// timestamps. Output channel: out_valid_o / out_stall_i / out_data_o carries
// the valid flag and the absolute difference in days, hours, minutes and
// seconds, all zero when any field of either timestamp is out of range.
// A word moves at a rising edge where valid is high and stall is low.
// A word accepted at the input moves through the stage registers in order to
// the output register; one word can enter every cycle while a stage is free.
// The four stages are: quotient and year multiply, day-number sum, ordering,
// borrow subtraction. Each stage has its own valid bit and loads whenever it
// is empty or the stage after it moves, so bubbles close up and a stalled
// result still lets new words enter until every stage is full.
// Reset clears only the valid bits; the data registers are not reset.
// While out_stall_i holds a result, it and the words behind it stay put.

module datetime_difference_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dtd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dtd_pkg::out_t out_data_o
);

  logic [dtd_pkg::NUM_STAGES-1:0] vld_d, vld_q;
  logic [dtd_pkg::NUM_STAGES:0]   ready;

  always_comb begin
    ready[dtd_pkg::NUM_STAGES] = !out_stall_i;
    for (int k = dtd_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      ready[k] = !vld_q[k] || ready[k+1];
    end
    vld_d[0] = in_valid_i;
    for (int k = 1; k < dtd_pkg::NUM_STAGES; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < dtd_pkg::NUM_STAGES; k++) begin
        if (ready[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  dtd_pkg::stage_en_t conv_en, diff_en;
  dtd_pkg::stamp_t    stamp_first, stamp_second;
  dtd_pkg::norm_t     norm_first, norm_second;

  always_comb begin
    conv_en.en_a = ready[0];
    conv_en.en_b = ready[1];
    diff_en.en_a = ready[2];
    diff_en.en_b = ready[3];

    stamp_first.day      = in_data_i.first_day;
    stamp_first.month    = in_data_i.first_month;
    stamp_first.year     = in_data_i.first_year;
    stamp_first.hours    = in_data_i.first_hours;
    stamp_first.minutes  = in_data_i.first_minutes;
    stamp_first.seconds  = in_data_i.first_seconds;

    stamp_second.day     = in_data_i.second_day;
    stamp_second.month   = in_data_i.second_month;
    stamp_second.year    = in_data_i.second_year;
    stamp_second.hours   = in_data_i.second_hours;
    stamp_second.minutes = in_data_i.second_minutes;
    stamp_second.seconds = in_data_i.second_seconds;
  end

  dtd_conv u_conv_first (
    .clk_i   (clk_i),
    .en_i    (conv_en),
    .stamp_i (stamp_first),
    .norm_o  (norm_first)
  );

  dtd_conv u_conv_second (
    .clk_i   (clk_i),
    .en_i    (conv_en),
    .stamp_i (stamp_second),
    .norm_o  (norm_second)
  );

  dtd_diff u_diff (
    .clk_i    (clk_i),
    .en_i     (diff_en),
    .first_i  (norm_first),
    .second_i (norm_second),
    .res_o    (out_data_o)
  );

  assign in_stall_o  = !ready[0];
  assign out_valid_o = vld_q[dtd_pkg::NUM_STAGES-1];

`ifndef SYNTHESIS
  // input backs up only when every stage holds a word and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&vld_q) && out_stall_i))
    else $error("input stalled with a free pipeline stage");

  // a flagged-invalid result carries an all-zero difference
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.valid_res) |->
      (out_data_o.diff_days == '0) && (out_data_o.diff_hours == '0)
      && (out_data_o.diff_minutes == '0) && (out_data_o.diff_seconds == '0))
    else $error("invalid result with nonzero difference");

  // a valid difference keeps its time-of-day parts in range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.valid_res) |->
      (out_data_o.diff_hours < dtd_pkg::HOURS_PER_DAY)
      && (out_data_o.diff_minutes < dtd_pkg::MINS_PER_HOUR)
      && (out_data_o.diff_seconds < dtd_pkg::SECS_PER_MIN))
    else $error("difference field out of range");
`endif

endmodule

// ===== verif/tb_top.sv =====
// self-checking testbench of the datetime difference block
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_WORDS = 450;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    F_DAY, F_MONTH, F_YEAR, F_HOURS, F_MINUTES, F_SECONDS
  } stamp_field_e;

  // predicts the calendar difference of each accepted word and checks results in order
  class span_board;
    dtd_pkg::out_t spans_due[$];
    int unsigned errors = 0;

    function bit leap(logic [13:0] y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function logic [4:0] month_days(logic [3:0] m, logic [13:0] y);
      case (m) inside
        dtd_pkg::MONTH_FEB:         return leap(y) ? 5'd29 : 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
        4'd0, 4'd13, 4'd14, 4'd15: return 5'd0;
        default:                    return 5'd31;
      endcase
    endfunction

    function bit stamp_ok(dtd_pkg::stamp_t s);
      if (s.year >= dtd_pkg::YEAR_LIMIT || s.month == 4'd0 || s.month > dtd_pkg::MONTH_DEC)
        return 1'b0;
      if (s.day == 5'd0 || s.day > month_days(s.month, s.year)) return 1'b0;
      return s.hours < dtd_pkg::HOURS_PER_DAY && s.minutes < dtd_pkg::MINS_PER_HOUR
             && s.seconds < dtd_pkg::SECS_PER_MIN;
    endfunction

    // seconds from the day before the start of year 0, which counts as leap
    function longint unsigned stamp_secs(dtd_pkg::stamp_t s);
      longint unsigned yr;
      longint unsigned days;
      logic [3:0] m;
      yr = 64'(s.year);
      days = yr * 365 + 64'(s.day);
      if (yr != 0) days += (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 + 1;
      for (m = dtd_pkg::MONTH_JAN; m < s.month; m++) days += 64'(month_days(m, 14'd1));
      if (s.month >= dtd_pkg::MONTH_MAR && leap(s.year)) days++;
      return days * 86400 + 64'(s.hours) * 3600 + 64'(s.minutes) * 60 + 64'(s.seconds);
    endfunction

    function dtd_pkg::out_t calc_span(dtd_pkg::in_t w);
      dtd_pkg::stamp_t a;
      dtd_pkg::stamp_t b;
      longint unsigned ta;
      longint unsigned tb;
      longint unsigned gap;
      longint unsigned rest;
      dtd_pkg::out_t r;
      r = '0;
      {a, b} = w;
      if (!stamp_ok(a) || !stamp_ok(b)) return r;
      ta = stamp_secs(a);
      tb = stamp_secs(b);
      gap = (ta > tb) ? ta - tb : tb - ta;
      rest = gap % 86400;
      r.valid_res    = 1'b1;
      r.diff_days    = 22'(gap / 86400);
      r.diff_hours   = 5'(rest / 3600);
      rest = rest % 3600;
      r.diff_minutes = 6'(rest / 60);
      r.diff_seconds = 6'(rest % 60);
      return r;
    endfunction

    function void note_pair(dtd_pkg::in_t w);
      spans_due.push_back(calc_span(w));
    endfunction

    function int pending();
      return spans_due.size();
    endfunction

    function void check_span(dtd_pkg::out_t got);
      dtd_pkg::out_t want;
      string bad;
      bad = "";
      if (spans_due.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result word: valid %0b %0d days %0d:%0d:%0d", got.valid_res,
                   got.diff_days, got.diff_hours, got.diff_minutes, got.diff_seconds);
        return;
      end
      want = spans_due.pop_front();
      if (got.valid_res !== want.valid_res) bad = {bad, " valid_res"};
      if (got.diff_days !== want.diff_days) bad = {bad, " diff_days"};
      if (got.diff_hours !== want.diff_hours) bad = {bad, " diff_hours"};
      if (got.diff_minutes !== want.diff_minutes) bad = {bad, " diff_minutes"};
      if (got.diff_seconds !== want.diff_seconds) bad = {bad, " diff_seconds"};
      if (bad != "") begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("result mismatch in%s: expected valid %0b %0d days %0d:%0d:%0d",
                   bad, want.valid_res, want.diff_days, want.diff_hours, want.diff_minutes,
                   want.diff_seconds);
          $display("  got valid %0b %0d days %0d:%0d:%0d", got.valid_res, got.diff_days,
                   got.diff_hours, got.diff_minutes, got.diff_seconds);
        end
      end
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  dtd_pkg::in_t  in_data_i;
  logic          out_valid_o;
  logic          out_stall_i;
  dtd_pkg::out_t out_data_o;

  span_board board = new();

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_flip = 1'b0;

  datetime_difference_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_pair(in_data_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_span(out_data_o);
  end

  // receiver: random stalls, or a long hold-off each time hold_flip toggles
  initial begin
    int unsigned hold_left;
    bit hold_seen;
    out_stall_i = 1'b0;
    hold_left = 0;
    hold_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_flip != hold_seen) begin
        hold_seen = hold_flip;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic dtd_pkg::stamp_t stamp(int unsigned d, int unsigned m, int unsigned y,
                                            int unsigned h, int unsigned mi, int unsigned s);
    dtd_pkg::stamp_t r;
    r.day     = 5'(d);
    r.month   = 4'(m);
    r.year    = 14'(y);
    r.hours   = 5'(h);
    r.minutes = 6'(mi);
    r.seconds = 6'(s);
    return r;
  endfunction

  function automatic dtd_pkg::stamp_t valid_stamp();
    dtd_pkg::stamp_t s;
    // leap rule corners and range ends come up often
    if ($urandom_range(4) == 0) begin
      case ($urandom_range(7))
        0:       s.year = 14'd0;
        1:       s.year = 14'd1;
        2:       s.year = 14'd4;
        3:       s.year = 14'd100;
        4:       s.year = 14'd400;
        5:       s.year = 14'd1900;
        6:       s.year = 14'd2000;
        default: s.year = 14'd9998;
      endcase
    end else begin
      s.year = 14'($urandom_range(9998));
    end
    s.month   = 4'($urandom_range(12, 1));
    s.day     = 5'($urandom_range(board.month_days(s.month, s.year), 1));
    s.hours   = 5'($urandom_range(23));
    s.minutes = 6'($urandom_range(59));
    s.seconds = 6'($urandom_range(59));
    return s;
  endfunction

  function automatic dtd_pkg::stamp_t spoil(dtd_pkg::stamp_t s);
    stamp_field_e f;
    logic [4:0] md;
    f = stamp_field_e'($urandom_range(5));
    md = board.month_days(s.month, s.year);
    case (f)
      F_DAY:     s.day = (md == 5'd31 || $urandom_range(1)) ? 5'd0
                         : 5'($urandom_range(31, md + 1));
      F_MONTH:   s.month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
      F_YEAR:    s.year = 14'($urandom_range(16383, 9999));
      F_HOURS:   s.hours = 5'($urandom_range(31, 24));
      F_MINUTES: s.minutes = 6'($urandom_range(63, 60));
      default:   s.seconds = 6'($urandom_range(63, 60));
    endcase
    return s;
  endfunction

  function automatic dtd_pkg::in_t random_pair();
    dtd_pkg::stamp_t a;
    dtd_pkg::stamp_t b;
    logic [63:0] rnd;
    int unsigned pick;
    pick = $urandom_range(99);
    a = valid_stamp();
    b = valid_stamp();
    if (pick >= 55 && pick < 70) begin
      // nearby or equal stamps give small differences
      b = a;
      if (pick >= 58) b.seconds = 6'($urandom_range(59));
      if (pick >= 62) b.minutes = 6'($urandom_range(59));
      if (pick >= 65) b.hours = 5'($urandom_range(23));
      if (pick >= 67) b.day = 5'($urandom_range(board.month_days(b.month, b.year), 1));
    end else if (pick >= 70 && pick < 85) begin
      if ($urandom_range(1)) a = spoil(a);
      else b = spoil(b);
    end else if (pick >= 85) begin
      rnd = {$urandom(), $urandom()};
      a = dtd_pkg::stamp_t'(rnd[39:0]);
      rnd = {$urandom(), $urandom()};
      b = dtd_pkg::stamp_t'(rnd[39:0]);
    end
    return $urandom_range(1) ? {a, b} : {b, a};
  endfunction

  task automatic send_pair(input dtd_pkg::in_t w);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_random(input int unsigned count);
    repeat (count) send_pair(random_pair());
  endtask

  // drop valid, then wait for every outstanding result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    dtd_pkg::stamp_t lo;
    dtd_pkg::stamp_t hi;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    lo = stamp(1, 1, 0, 0, 0, 0);
    hi = stamp(31, 12, 9998, 23, 59, 59);
    send_pair({lo, lo});
    send_pair({lo, hi});
    send_pair({hi, lo});
    send_pair({stamp(31, 12, 1999, 23, 59, 59), stamp(1, 1, 2000, 0, 0, 0)});
    send_pair({stamp(29, 2, 2000, 12, 0, 0), stamp(1, 3, 1900, 0, 0, 0)});
    send_pair({stamp(29, 2, 0, 0, 0, 0), lo});
    send_pair({stamp(29, 2, 1900, 0, 0, 0), lo});
    send_pair({stamp(29, 2, 2023, 8, 0, 0), lo});
    send_pair({lo, stamp(30, 2, 2024, 0, 0, 0)});
    send_pair({stamp(31, 4, 2020, 0, 0, 0), lo});
    send_pair({stamp(0, 5, 2020, 0, 0, 0), lo});
    send_pair({stamp(1, 0, 2020, 0, 0, 0), lo});
    send_pair({lo, stamp(1, 13, 2020, 0, 0, 0)});
    send_pair({stamp(31, 15, 16383, 31, 63, 63), stamp(31, 15, 16383, 31, 63, 63)});
    send_pair({stamp(1, 1, 9999, 0, 0, 0), lo});
    send_pair({lo, stamp(1, 1, 2020, 24, 0, 0)});
    send_pair({lo, stamp(1, 1, 2020, 0, 60, 0)});
    send_pair({lo, stamp(1, 1, 2020, 0, 0, 60)});
    send_pair({stamp(1, 1, 2020, 31, 63, 63), lo});
    send_pair({stamp(0, 0, 0, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0)});
    send_pair({stamp(29, 2, 2024, 23, 59, 59), stamp(1, 3, 2024, 0, 0, 0)});
    send_pair({hi, stamp(31, 12, 9998, 23, 59, 58)});
    send_pair({stamp(15, 6, 2400, 6, 30, 30), stamp(15, 6, 2100, 18, 45, 15)});

    send_random(PHASE_WORDS);

    // receiver holds off while words keep coming until the pipeline backs up
    hold_flip = ~hold_flip;
    send_random(60);
    drain_results();

    send_idle_pct = 65;
    stall_pct = 0;
    send_random(PHASE_WORDS);

    send_idle_pct = 0;
    stall_pct = 65;
    send_random(PHASE_WORDS);

    send_idle_pct = 17;
    stall_pct = 17;
    send_random(PHASE_WORDS);

    stall_pct = 0;
    drain_results();
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dtd_pkg.sv
sv/dtd_conv.sv
sv/dtd_diff.sv
sv/datetime_difference_top.sv
verif/tb_top.sv
